// ===== rtl/core/yuv_to_rgb_3d_lut_grader_core_macros.svh =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_3d_lut_grader_core_macros
// assertion helpers shared by the grader rtl
// ----------------------------------------------------------------------------
`ifndef YUV_TO_RGB_3D_LUT_GRADER_CORE_MACROS_SVH
`define YUV_TO_RGB_3D_LUT_GRADER_CORE_MACROS_SVH

// condition must never hold outside reset
`define YLUT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define YLUT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ylut_pkg.sv =====
// ----------------------------------------------------------------------------
// ylut_pkg
// shared constants, types and helpers of the ycbcr 3d lut grader
// ----------------------------------------------------------------------------
`default_nettype none

package ylut_pkg;

  localparam int unsigned GridPointsDef = 33;
  localparam int unsigned EntryBitsDef  = 16;

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncPixel = 1'b1
  } func_e;

  // bt.601 video range coefficients, scaled by 256
  localparam int CoefY   = 298;
  localparam int CoefRv  = 409;
  localparam int CoefGu  = 100;
  localparam int CoefGv  = 208;
  localparam int CoefBu  = 516;
  localparam int OffY    = 16;
  localparam int OffC    = 128;
  localparam int RoundN  = 128;
  localparam int NumMax  = 65280;

  // floor(2^30 / 255) for the divide by 255
  localparam int unsigned Recip255   = 4210752;
  localparam int unsigned Recip255Sh = 30;

  typedef struct packed {
    logic vld;
    logic pix;
  } ylut_ctrl_t;

  function automatic logic [15:0] clamp_num(logic signed [19:0] n);
    logic [15:0] r;
    if (n < 0) begin
      r = 16'd0;
    end else if (n > 20'(NumMax)) begin
      r = 16'(NumMax);
    end else begin
      r = n[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ylut_in_if.sv =====
// ----------------------------------------------------------------------------
// ylut_in_if
// input beat channel: table entry write or pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface ylut_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] entry_index;
  logic [15:0] entry_red;
  logic [15:0] entry_green;
  logic [15:0] entry_blue;
  logic [7:0]  luma;
  logic [7:0]  chroma_blue;
  logic [7:0]  chroma_red;

  modport source (
    output valid, func, entry_index, entry_red, entry_green, entry_blue,
           luma, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_red, entry_green, entry_blue,
           luma, chroma_blue, chroma_red,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/ylut_out_if.sv =====
// ----------------------------------------------------------------------------
// ylut_out_if
// graded rgb result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface ylut_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ylut_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ylut_cfg_if
// configuration write channel carrying the table enable bit
// ----------------------------------------------------------------------------
`default_nettype none

interface ylut_cfg_if;
  logic valid;
  logic ready;
  logic table_enable;

  modport source (output valid, table_enable, input ready);
  modport sink (input valid, table_enable, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ylut_ram.sv =====
// ----------------------------------------------------------------------------
// ylut_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ylut_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4913,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ylut_front.sv =====
// ----------------------------------------------------------------------------
// ylut_front
// color conversion, grid coordinates, entry index split and bank addressing
// ----------------------------------------------------------------------------
`default_nettype none

module ylut_front #(
  parameter int unsigned GridPoints = ylut_pkg::GridPointsDef,
  parameter int unsigned EntryBits  = ylut_pkg::EntryBitsDef,
  localparam int unsigned Half      = GridPoints / 2 + 1,
  localparam int unsigned AddrW     = $clog2(Half * Half * Half)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          beat_i,
  input  wire logic                          func_i,
  input  wire logic [15:0]                   entry_index_i,
  input  wire logic [15:0]                   entry_red_i,
  input  wire logic [15:0]                   entry_green_i,
  input  wire logic [15:0]                   entry_blue_i,
  input  wire logic [7:0]                    luma_i,
  input  wire logic [7:0]                    chroma_blue_i,
  input  wire logic [7:0]                    chroma_red_i,
  output ylut_pkg::ylut_ctrl_t               ctrl_o,
  output logic      [7:0]                    bank_we_o,
  output logic      [7:0][AddrW-1:0]         bank_addr_o,
  output logic      [3*EntryBits-1:0]        wdata_o,
  output logic      [2:0][15:0]              frac_o,
  output logic      [2:0]                    par_o,
  output logic      [2:0][7:0]               pass_o
);

  localparam int unsigned CW     = $clog2(GridPoints);
  localparam int unsigned HW     = $clog2(Half);
  localparam int unsigned MW     = 16 + CW;
  localparam int unsigned QW     = MW - 7;
  localparam int unsigned EW     = 3 * EntryBits;
  localparam int unsigned TableN = GridPoints * GridPoints * GridPoints;
  localparam logic [47:0] RecipG = 48'((64'd1 << 32) / GridPoints);

  function automatic logic [HW-1:0] half_pt(logic [CW-1:0] p, logic sel);
    logic [CW:0] pt;
    pt = (CW+1)'(p) + (CW+1)'(p[0] ^ sel);
    return HW'(pt >> 1);
  endfunction

  function automatic logic [AddrW-1:0] bank_addr(logic [HW-1:0] hx, logic [HW-1:0] hy,
                                                 logic [HW-1:0] hz);
    return AddrW'((AddrW'(hz) * AddrW'(Half) + AddrW'(hy)) * AddrW'(Half) + AddrW'(hx));
  endfunction

  // ---------------- stage 1: conversion numerators, first index split
  logic signed [9:0]  c_s, d_s, e_s;
  logic signed [19:0] nr_w, ng_w, nb_w;
  logic [2:0][15:0]   n_w;
  logic [2:0][7:0]    pass_w;
  logic [47:0]        prod1_w;

  assign c_s = $signed({2'b00, luma_i}) - 10'(ylut_pkg::OffY);
  assign d_s = $signed({2'b00, chroma_blue_i}) - 10'(ylut_pkg::OffC);
  assign e_s = $signed({2'b00, chroma_red_i}) - 10'(ylut_pkg::OffC);

  assign nr_w = 20'(ylut_pkg::CoefY * c_s + ylut_pkg::CoefRv * e_s + ylut_pkg::RoundN);
  assign ng_w = 20'(ylut_pkg::CoefY * c_s - ylut_pkg::CoefGu * d_s - ylut_pkg::CoefGv * e_s
                    + ylut_pkg::RoundN);
  assign nb_w = 20'(ylut_pkg::CoefY * c_s + ylut_pkg::CoefBu * d_s + ylut_pkg::RoundN);

  assign n_w[0] = ylut_pkg::clamp_num(nr_w);
  assign n_w[1] = ylut_pkg::clamp_num(ng_w);
  assign n_w[2] = ylut_pkg::clamp_num(nb_w);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pass_w[k] = 8'((17'(n_w[k]) + 17'd128) >> 8);
    end
  end

  assign prod1_w = 48'(entry_index_i) * RecipG;

  ylut_pkg::ylut_ctrl_t s1_ctrl_q, s2_ctrl_q, s3_ctrl_q, s4_ctrl_q, s5_ctrl_q;
  logic [2:0][15:0] s1_n_q;
  logic [2:0][7:0]  s1_pass_q, s2_pass_q, s3_pass_q, s4_pass_q, s5_pass_q;
  logic [EW-1:0]    s1_ent_q, s2_ent_q, s3_ent_q, s4_ent_q, s5_ent_q;
  logic [15:0]      s1_idx_q, s1_q1e_q;
  logic             s1_ok_q, s2_ok_q, s3_ok_q, s4_ok_q;

  // ---------------- stage 2: scale by grid size, finish first split
  logic [2:0][MW-1:0] m_w;
  logic [23:0]        r1_w;
  logic [CW-1:0]      x_w;
  logic [15:0]        q1_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_w[k] = MW'(s1_n_q[k]) * MW'(GridPoints - 1);
    end
    r1_w = 24'(s1_idx_q) - 24'(s1_q1e_q) * 24'(GridPoints);
    if (r1_w >= 24'(GridPoints)) begin
      x_w  = CW'(r1_w - 24'(GridPoints));
      q1_w = s1_q1e_q + 16'd1;
    end else begin
      x_w  = CW'(r1_w);
      q1_w = s1_q1e_q;
    end
  end

  logic [2:0][MW-1:0] s2_m_q, s3_m_q;
  logic [CW-1:0]      s2_x_q, s3_x_q, s4_x_q;
  logic [15:0]        s2_q1_q, s3_q1_q, s3_q2e_q;

  // ---------------- stage 3: reciprocal multiplies
  logic [2:0][QW-1:0]  qe_w;
  logic [MW+22:0]      pr_w [3];
  logic [47:0]         prod2_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_w[k] = (MW+23)'(s2_m_q[k]) * (MW+23)'(ylut_pkg::Recip255);
      qe_w[k] = QW'(pr_w[k] >> ylut_pkg::Recip255Sh);
    end
  end

  assign prod2_w = 48'(s2_q1_q) * RecipG;

  logic [2:0][QW-1:0] s3_qe_q;

  // ---------------- stage 4: quotient correction, grid point and fraction
  logic [2:0][CW-1:0] p_w;
  logic [2:0][15:0]   f_w;
  logic [MW-1:0]      r3_w;
  logic [QW-1:0]      qf_w;
  logic [MW:0]        c_w;
  logic [CW:0]        pr0_w;
  logic [23:0]        r2_w;
  logic [CW-1:0]      y_w, z_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r3_w  = s3_m_q[k] - MW'(s3_qe_q[k]) * MW'(255);
      qf_w  = (r3_w >= MW'(255)) ? s3_qe_q[k] + QW'(1) : s3_qe_q[k];
      c_w   = (MW+1)'(s3_m_q[k]) + (MW+1)'(qf_w);
      pr0_w = c_w[MW:16];
      p_w[k] = (pr0_w > (CW+1)'(GridPoints - 1)) ? CW'(GridPoints - 1) : CW'(pr0_w);
      f_w[k] = c_w[15:0];
    end
    r2_w = 24'(s3_q1_q) - 24'(s3_q2e_q) * 24'(GridPoints);
    if (r2_w >= 24'(GridPoints)) begin
      y_w = CW'(r2_w - 24'(GridPoints));
      z_w = CW'(s3_q2e_q + 16'd1);
    end else begin
      y_w = CW'(r2_w);
      z_w = CW'(s3_q2e_q);
    end
  end

  logic [2:0][CW-1:0] s4_p_q;
  logic [2:0][15:0]   s4_f_q, s5_f_q;
  logic [CW-1:0]      s4_y_q, s4_z_q;

  // ---------------- stage 5: per bank address, eight corners by parity
  logic [7:0][AddrW-1:0] addr_w;
  logic [7:0]            we_w;
  logic [2:0]            wbank_w;
  logic [AddrW-1:0]      waddr_w;
  logic [AddrW-1:0]      raddr_w;

  always_comb begin
    wbank_w = {s4_z_q[0], s4_y_q[0], s4_x_q[0]};
    waddr_w = bank_addr(HW'(s4_x_q >> 1), HW'(s4_y_q >> 1), HW'(s4_z_q >> 1));
    for (int b = 0; b < 8; b++) begin
      raddr_w = bank_addr(half_pt(s4_p_q[0], 1'(b)), half_pt(s4_p_q[1], 1'(b >> 1)),
                          half_pt(s4_p_q[2], 1'(b >> 2)));
      addr_w[b] = s4_ctrl_q.pix ? raddr_w : waddr_w;
      we_w[b]   = s4_ctrl_q.vld && !s4_ctrl_q.pix && s4_ok_q && (wbank_w == 3'(b));
    end
  end

  logic [7:0]            s5_we_q;
  logic [7:0][AddrW-1:0] s5_addr_q;
  logic [2:0]            s5_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
      s2_ctrl_q <= '0;
      s3_ctrl_q <= '0;
      s4_ctrl_q <= '0;
      s5_ctrl_q <= '0;
      s5_we_q   <= '0;
    end else if (en_i) begin
      s1_ctrl_q <= '{vld: beat_i, pix: (func_i == ylut_pkg::FuncPixel)};
      s2_ctrl_q <= s1_ctrl_q;
      s3_ctrl_q <= s2_ctrl_q;
      s4_ctrl_q <= s3_ctrl_q;
      s5_ctrl_q <= s4_ctrl_q;
      s5_we_q   <= we_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_n_q    <= n_w;
      s1_pass_q <= pass_w;
      s1_ent_q  <= {entry_blue_i[EntryBits-1:0], entry_green_i[EntryBits-1:0],
                    entry_red_i[EntryBits-1:0]};
      s1_idx_q  <= entry_index_i;
      s1_q1e_q  <= prod1_w[47:32];
      s1_ok_q   <= (32'(entry_index_i) < 32'(TableN));

      s2_m_q    <= m_w;
      s2_x_q    <= x_w;
      s2_q1_q   <= q1_w;
      s2_pass_q <= s1_pass_q;
      s2_ent_q  <= s1_ent_q;
      s2_ok_q   <= s1_ok_q;

      s3_m_q    <= s2_m_q;
      s3_qe_q   <= qe_w;
      s3_x_q    <= s2_x_q;
      s3_q1_q   <= s2_q1_q;
      s3_q2e_q  <= prod2_w[47:32];
      s3_pass_q <= s2_pass_q;
      s3_ent_q  <= s2_ent_q;
      s3_ok_q   <= s2_ok_q;

      s4_p_q    <= p_w;
      s4_f_q    <= f_w;
      s4_x_q    <= s3_x_q;
      s4_y_q    <= y_w;
      s4_z_q    <= z_w;
      s4_pass_q <= s3_pass_q;
      s4_ent_q  <= s3_ent_q;
      s4_ok_q   <= s3_ok_q;

      s5_addr_q <= addr_w;
      s5_f_q    <= s4_f_q;
      s5_par_q  <= {s4_p_q[2][0], s4_p_q[1][0], s4_p_q[0][0]};
      s5_pass_q <= s4_pass_q;
      s5_ent_q  <= s4_ent_q;
    end
  end

  assign ctrl_o      = s5_ctrl_q;
  assign bank_we_o   = s5_we_q;
  assign bank_addr_o = s5_addr_q;
  assign wdata_o     = s5_ent_q;
  assign frac_o      = s5_f_q;
  assign par_o       = s5_par_q;
  assign pass_o      = s5_pass_q;

endmodule

`default_nettype wire

// ===== rtl/core/ylut_interp.sv =====
// ----------------------------------------------------------------------------
// ylut_interp
// trilinear interpolation over the eight bank reads and output scaling
// ----------------------------------------------------------------------------
`default_nettype none

module ylut_interp #(
  parameter int unsigned EntryBits = ylut_pkg::EntryBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             table_en_i,
  input  wire ylut_pkg::ylut_ctrl_t             ctrl_i,
  input  wire logic [2:0][15:0]                 frac_i,
  input  wire logic [2:0]                       par_i,
  input  wire logic [2:0][7:0]                  pass_i,
  input  wire logic [7:0][3*EntryBits-1:0]      rdata_i,
  output logic                                  valid_o,
  output logic      [7:0]                       red_o,
  output logic      [7:0]                       green_o,
  output logic      [7:0]                       blue_o
);

  localparam int unsigned EB = EntryBits;
  localparam int unsigned SW = EB + 18;

  // a + round((b - a) * f / 2^16), identical to the two-product form
  function automatic logic [EB-1:0] lerp(logic [EB-1:0] a, logic [EB-1:0] b,
                                         logic [15:0] f);
    logic signed [EB:0]   dif;
    logic signed [SW-1:0] prod;
    logic signed [SW-1:0] sum;
    // zero fraction ignores the upper sample, which may sit past the grid
    dif  = (f == 16'd0) ? '0 : $signed({1'b0, b}) - $signed({1'b0, a});
    prod = SW'(dif) * SW'($signed({1'b0, f}));
    sum  = prod + SW'(32768);
    return EB'(SW'($signed({1'b0, a})) + (sum >>> 16));
  endfunction

  // ---------------- stage 6: side data alongside the registered reads
  logic             s6_vld_q, s7_vld_q, s8_vld_q, s9_vld_q, out_vld_q;
  logic [2:0][15:0] s6_f_q;
  logic [2:0]       s6_par_q;
  logic [2:0][7:0]  s6_pass_q, s7_pass_q, s8_pass_q, s9_pass_q;

  // ---------------- stage 7: along red
  logic [2:0][1:0][1:0][EB-1:0] ax_w;
  logic [2:0]                   sel0_w, sel1_w;

  always_comb begin
    sel0_w = '0;
    sel1_w = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          sel0_w = 3'(k * 4 + j * 2) ^ s6_par_q;
          sel1_w = 3'(k * 4 + j * 2 + 1) ^ s6_par_q;
          ax_w[ch][j][k] = lerp(rdata_i[sel0_w][ch*EB +: EB], rdata_i[sel1_w][ch*EB +: EB],
                                s6_f_q[0]);
        end
      end
    end
  end

  logic [2:0][1:0][1:0][EB-1:0] s7_ax_q;
  logic [1:0][15:0]             s7_f_q;

  // ---------------- stage 8: along green
  logic [2:0][1:0][EB-1:0] by_w;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 2; k++) begin
        by_w[ch][k] = lerp(s7_ax_q[ch][0][k], s7_ax_q[ch][1][k], s7_f_q[0]);
      end
    end
  end

  logic [2:0][1:0][EB-1:0] s8_by_q;
  logic [15:0]             s8_fz_q;

  // ---------------- stage 9: along blue
  logic [2:0][EB-1:0] v_w;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      v_w[ch] = lerp(s8_by_q[ch][0], s8_by_q[ch][1], s8_fz_q);
    end
  end

  logic [2:0][EB-1:0] s9_v_q;

  // ---------------- stage 10: back to 8 bits, or pass-through rgb with the table off
  logic [2:0][7:0] o_w;
  logic [EB+8:0]   sc_w;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sc_w = ((EB+9)'(s9_v_q[ch]) * (EB+9)'(255) + (EB+9)'(1 << (EB - 1))) >> EB;
      if (!table_en_i) begin
        o_w[ch] = s9_pass_q[ch];
      end else if (sc_w > (EB+9)'(255)) begin
        o_w[ch] = 8'd255;
      end else begin
        o_w[ch] = 8'(sc_w);
      end
    end
  end

  logic [2:0][7:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s6_vld_q  <= ctrl_i.vld && ctrl_i.pix;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      out_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_f_q    <= frac_i;
      s6_par_q  <= par_i;
      s6_pass_q <= pass_i;
      s7_ax_q   <= ax_w;
      s7_f_q    <= {s6_f_q[2], s6_f_q[1]};
      s7_pass_q <= s6_pass_q;
      s8_by_q   <= by_w;
      s8_fz_q   <= s7_f_q[1];
      s8_pass_q <= s7_pass_q;
      s9_v_q    <= v_w;
      s9_pass_q <= s8_pass_q;
      out_q     <= o_w;
    end
  end

  assign valid_o = out_vld_q;
  assign red_o   = out_q[0];
  assign green_o = out_q[1];
  assign blue_o  = out_q[2];

endmodule

`default_nettype wire

// ===== rtl/core/yuv_to_rgb_3d_lut_grader_core.sv =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_3d_lut_grader_core
// ycbcr to rgb conversion followed by a trilinear 3d color table
// ----------------------------------------------------------------------------
// pix_in carries one beat per item: func 0 writes one table entry (no result),
// func 1 carries a pixel whose graded rgb leaves on pix_out. cfg sets
// table_enable (0 passes converted rgb through) and is always ready; write it
// only while the pipeline is empty.
// one beat per cycle is taken and one result per cycle leaves while pix_out is
// not stalled. a pixel result passes through conversion and coordinate math, a
// stage that forms bank addresses, the ram read, three lerp passes along red,
// green and blue, and the output register.
// the table lives in eight rams, one per parity of the red, green and blue
// grid coordinates, so the eight corners of a cell are read in the same cycle.
// reset clears the pipeline valids and table_enable; table contents are
// undefined until written and no clearing pass runs.
// when pix_out is stalled the whole pipeline holds, including the ram read
// registers, and pix_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "yuv_to_rgb_3d_lut_grader_core_macros.svh"

module yuv_to_rgb_3d_lut_grader_core #(
  parameter int unsigned GridPoints = ylut_pkg::GridPointsDef,
  parameter int unsigned EntryBits  = ylut_pkg::EntryBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ylut_cfg_if.sink    cfg,
  ylut_in_if.sink     pix_in,
  ylut_out_if.source  pix_out
);

  localparam int unsigned Half  = GridPoints / 2 + 1;
  localparam int unsigned Depth = Half * Half * Half;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned EW    = 3 * EntryBits;

  logic en;
  logic table_en_q;

  ylut_pkg::ylut_ctrl_t  ctrl;
  logic [7:0]            bank_we;
  logic [7:0][AddrW-1:0] bank_addr;
  logic [EW-1:0]         wdata;
  logic [2:0][15:0]      frac;
  logic [2:0]            par;
  logic [2:0][7:0]       pass;
  logic [7:0][EW-1:0]    rdata;

  // the pipeline moves as a whole unless the output register is held
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_en_q <= 1'b0;
    end else if (cfg.valid) begin
      table_en_q <= cfg.table_enable;
    end
  end

  ylut_front #(
    .GridPoints (GridPoints),
    .EntryBits  (EntryBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .beat_i        (pix_in.valid && en),
    .func_i        (pix_in.func),
    .entry_index_i (pix_in.entry_index),
    .entry_red_i   (pix_in.entry_red),
    .entry_green_i (pix_in.entry_green),
    .entry_blue_i  (pix_in.entry_blue),
    .luma_i        (pix_in.luma),
    .chroma_blue_i (pix_in.chroma_blue),
    .chroma_red_i  (pix_in.chroma_red),
    .ctrl_o        (ctrl),
    .bank_we_o     (bank_we),
    .bank_addr_o   (bank_addr),
    .wdata_o       (wdata),
    .frac_o        (frac),
    .par_o         (par),
    .pass_o        (pass)
  );

  for (genvar b = 0; b < 8; b++) begin : g_bank
    ylut_ram #(
      .Width (EW),
      .Depth (Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b] && en),
      .re_i    (en),
      .addr_i  (bank_addr[b]),
      .wdata_i (wdata),
      .rdata_o (rdata[b])
    );
  end

  ylut_interp #(
    .EntryBits (EntryBits)
  ) u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .table_en_i (table_en_q),
    .ctrl_i     (ctrl),
    .frac_i     (frac),
    .par_i      (par),
    .pass_i     (pass),
    .rdata_i    (rdata),
    .valid_o    (pix_out.valid),
    .red_o      (pix_out.red),
    .green_o    (pix_out.green),
    .blue_o     (pix_out.blue)
  );

  `YLUT_ASSERT_NEVER(a_one_bank_write, clk_i, rst_ni, !$onehot0(bank_we), "entry write hits several banks")
  `YLUT_ASSERT_IMPL(a_write_not_pixel, clk_i, rst_ni, bank_we != 8'd0, ctrl.vld && !ctrl.pix, "bank write from a pixel beat")
  `YLUT_ASSERT_IMPL(a_valid_rise_moved, clk_i, rst_ni, $rose(pix_out.valid), $past(en), "result appeared during a stall")

endmodule

`default_nettype wire

// ===== verif/yuv_to_rgb_3d_lut_grader_core_tb.sv =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_3d_lut_grader_core_tb
// self-checking bench for the ycbcr to rgb 3d table grader
// ----------------------------------------------------------------------------
// runs directed and random pixel and entry write beats with table grading off
// and on. before a graded pixel, any of its eight cell corners not yet written
// gets an entry write. the scoreboard predicts each pixel's graded rgb and
// checks results in order. both channel sides stall at random in three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_to_rgb_3d_lut_grader_core_tb;

  localparam int unsigned Grid      = ylut_pkg::GridPointsDef;
  localparam int unsigned TableSize = Grid * Grid * Grid;
  localparam int unsigned DogLimit  = 4000;

  typedef struct {
    ylut_pkg::func_e func;
    logic [15:0]     index;
    logic [15:0]     er;
    logic [15:0]     eg;
    logic [15:0]     eb;
    logic [7:0]      y;
    logic [7:0]      cb;
    logic [7:0]      cr;
  } beat_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  class grade_scoreboard;
    logic [15:0] grade_mem [TableSize][3];
    bit          written [TableSize];
    bit          grading_on;
    rgb_t        pending_rgb[$];
    int          fails;

    function automatic longint unsigned lerp(longint unsigned a, longint unsigned b,
                                             longint unsigned f);
      return (a * (65536 - f) + b * f + 32768) >> 16;
    endfunction

    function automatic int unsigned clamp(int n);
      if (n < 0) return 0;
      if (n > ylut_pkg::NumMax) return ylut_pkg::NumMax;
      return n;
    endfunction

    function automatic longint unsigned corner(int unsigned x, int unsigned y,
                                               int unsigned z, int ch);
      return 64'(grade_mem[(z * Grid + y) * Grid + x][ch]);
    endfunction

    function void convert(logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                          output int unsigned n[3]);
      int c, d, e;
      c = int'(y) - ylut_pkg::OffY;
      d = int'(cb) - ylut_pkg::OffC;
      e = int'(cr) - ylut_pkg::OffC;
      n[0] = clamp(ylut_pkg::CoefY * c + ylut_pkg::CoefRv * e + ylut_pkg::RoundN);
      n[1] = clamp(ylut_pkg::CoefY * c - ylut_pkg::CoefGu * d - ylut_pkg::CoefGv * e
                   + ylut_pkg::RoundN);
      n[2] = clamp(ylut_pkg::CoefY * c + ylut_pkg::CoefBu * d + ylut_pkg::RoundN);
    endfunction

    function void to_grid(int unsigned n, output int unsigned lo, output int unsigned hi,
                          output longint unsigned fr);
      longint unsigned crd;
      crd = (64'(n) * 64'(Grid - 1) * 64'd65536) / 64'(ylut_pkg::NumMax);
      lo = 32'(crd >> 16);
      if (lo > Grid - 1) lo = Grid - 1;
      hi = (lo + 1 < Grid) ? lo + 1 : Grid - 1;
      fr = crd & 64'hffff;
    endfunction

    // table entries a graded pixel reads
    function void corners(logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                          output int unsigned idx[8]);
      int unsigned n[3];
      int unsigned lo[3], hi[3], pt[3];
      longint unsigned fr;
      convert(y, cb, cr, n);
      for (int k = 0; k < 3; k++) to_grid(n[k], lo[k], hi[k], fr);
      for (int b = 0; b < 8; b++) begin
        pt[0] = ((b & 1) != 0) ? hi[0] : lo[0];
        pt[1] = ((b & 2) != 0) ? hi[1] : lo[1];
        pt[2] = ((b & 4) != 0) ? hi[2] : lo[2];
        idx[b] = (pt[2] * Grid + pt[1]) * Grid + pt[0];
      end
    endfunction

    function void note_beat(beat_t it);
      int unsigned n[3];
      int unsigned lo[3], hi[3];
      longint unsigned fr[3], a00, a10, a01, a11, b0, b1, v, o;
      rgb_t res;
      logic [7:0] ch_out[3];
      if (it.func == ylut_pkg::FuncWrite) begin
        if (it.index < TableSize) begin
          grade_mem[it.index][0] = it.er;
          grade_mem[it.index][1] = it.eg;
          grade_mem[it.index][2] = it.eb;
          written[it.index] = 1'b1;
        end
        return;
      end
      convert(it.y, it.cb, it.cr, n);
      if (!grading_on) begin
        for (int k = 0; k < 3; k++) ch_out[k] = 8'((n[k] + 32'd128) >> 8);
      end else begin
        for (int k = 0; k < 3; k++) to_grid(n[k], lo[k], hi[k], fr[k]);
        for (int ch = 0; ch < 3; ch++) begin
          a00 = lerp(corner(lo[0], lo[1], lo[2], ch), corner(hi[0], lo[1], lo[2], ch), fr[0]);
          a10 = lerp(corner(lo[0], hi[1], lo[2], ch), corner(hi[0], hi[1], lo[2], ch), fr[0]);
          a01 = lerp(corner(lo[0], lo[1], hi[2], ch), corner(hi[0], lo[1], hi[2], ch), fr[0]);
          a11 = lerp(corner(lo[0], hi[1], hi[2], ch), corner(hi[0], hi[1], hi[2], ch), fr[0]);
          b0 = lerp(a00, a10, fr[1]);
          b1 = lerp(a01, a11, fr[1]);
          v = lerp(b0, b1, fr[2]);
          o = (v * 255 + (64'd1 << (ylut_pkg::EntryBitsDef - 1))) >> ylut_pkg::EntryBitsDef;
          ch_out[ch] = (o > 255) ? 8'd255 : 8'(o);
        end
      end
      res.r = ch_out[0];
      res.g = ch_out[1];
      res.b = ch_out[2];
      pending_rgb.push_back(res);
    endfunction

    function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        $error("unexpected result beat r=%0d g=%0d b=%0d", r, g, b);
        fails++;
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want.r) begin
        $error("red: expected %0d, got %0d", want.r, r);
        fails++;
      end
      if (g !== want.g) begin
        $error("green: expected %0d, got %0d", want.g, g);
        fails++;
      end
      if (b !== want.b) begin
        $error("blue: expected %0d, got %0d", want.b, b);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int          src_idle;
  int          dst_idle;
  int          quiet_cycles;
  int          sent;
  logic [23:0] pixel_pool[$];

  ylut_cfg_if cfg_bus ();
  ylut_in_if  pix_in_bus ();
  ylut_out_if pix_out_bus ();

  grade_scoreboard sb;

  yuv_to_rgb_3d_lut_grader_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_bus.sink),
    .pix_in  (pix_in_bus.sink),
    .pix_out (pix_out_bus.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: random stalls, check at negedge when inputs are settled
  always @(posedge clk_i) begin
    pix_out_bus.ready <= ($urandom_range(99) >= dst_idle);
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        sb.check_rgb(pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue);
      end
      if ((pix_out_bus.valid && pix_out_bus.ready) || (pix_in_bus.valid && pix_in_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= DogLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(beat_t it);
    bit taken;
    while ($urandom_range(99) < src_idle) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in_bus.valid       <= 1'b1;
    pix_in_bus.func        <= it.func;
    pix_in_bus.entry_index <= it.index;
    pix_in_bus.entry_red   <= it.er;
    pix_in_bus.entry_green <= it.eg;
    pix_in_bus.entry_blue  <= it.eb;
    pix_in_bus.luma        <= it.y;
    pix_in_bus.chroma_blue <= it.cb;
    pix_in_bus.chroma_red  <= it.cr;
    do begin
      @(negedge clk_i);
      taken = pix_in_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_beat(it);
    sent++;
  endtask

  task automatic send_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    beat_t it;
    it.func = ylut_pkg::FuncPixel;
    it.index = 16'($urandom);
    it.er = 16'($urandom);
    it.eg = 16'($urandom);
    it.eb = 16'($urandom);
    it.y = y;
    it.cb = cb;
    it.cr = cr;
    send_beat(it);
  endtask

  function automatic logic [15:0] entry_value();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_entry(logic [15:0] idx);
    beat_t it;
    it.func = ylut_pkg::FuncWrite;
    it.index = idx;
    it.er = entry_value();
    it.eg = entry_value();
    it.eb = entry_value();
    it.y = 8'($urandom);
    it.cb = 8'($urandom);
    it.cr = 8'($urandom);
    send_beat(it);
  endtask

  // with grading on, corners not yet written are written before the pixel
  task automatic send_any(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    int unsigned idx[8];
    if (sb.grading_on) begin
      sb.corners(y, cb, cr, idx);
      for (int k = 0; k < 8; k++) begin
        if (!sb.written[idx[k]]) send_entry(16'(idx[k]));
      end
      pixel_pool.push_back({y, cb, cr});
    end
    send_pixel(y, cb, cr);
  endtask

  // pipeline is empty once nothing is pending and the write latency has passed
  task automatic wait_idle();
    pix_in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rgb.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_enable(bit en);
    bit taken;
    cfg_bus.valid        <= 1'b1;
    cfg_bus.table_enable <= en;
    do begin
      @(negedge clk_i);
      taken = cfg_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    cfg_bus.valid <= 1'b0;
    sb.grading_on = en;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(16, 235));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    int          stop;
    logic [23:0] px;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(99) < 70) begin
        if (pixel_pool.size() != 0 && $urandom_range(99) < 40) begin
          px = pixel_pool[$urandom_range(pixel_pool.size() - 1)];
        end else begin
          px = {rand_byte(), rand_byte(), rand_byte()};
        end
        send_any(px[23:16], px[15:8], px[7:0]);
      end else if ($urandom_range(19) == 0) begin
        send_entry(16'($urandom_range(TableSize, 65535)));
      end else begin
        send_entry(16'($urandom_range(TableSize - 1)));
      end
    end
  endtask

  task automatic directed_pixels();
    send_any(8'd0, 8'd0, 8'd0);
    send_any(8'd255, 8'd255, 8'd255);
    send_any(8'd16, 8'd128, 8'd128);
    send_any(8'd235, 8'd128, 8'd128); // full white lands on the top grid point
    send_any(8'd255, 8'd0, 8'd255);
    send_any(8'd0, 8'd255, 8'd0);
    send_any(8'd128, 8'd0, 8'd255);
    send_any(8'd128, 8'd255, 8'd0);
    send_any(8'd81, 8'd90, 8'd240);
  endtask

  initial begin
    sb = new();
    src_idle = 8;
    dst_idle = 68;
    quiet_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.table_enable = 1'b0;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.func = ylut_pkg::FuncWrite;
    pix_in_bus.entry_index = '0;
    pix_in_bus.entry_red = '0;
    pix_in_bus.entry_green = '0;
    pix_in_bus.entry_blue = '0;
    pix_in_bus.luma = '0;
    pix_in_bus.chroma_blue = '0;
    pix_in_bus.chroma_red = '0;
    pix_out_bus.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_enable(1'b0);
    directed_pixels();
    send_entry(16'(TableSize));
    send_entry(16'hffff);
    wait_idle();

    write_enable(1'b1);
    directed_pixels();
    random_phase(400);
    wait_idle();

    src_idle = 68;
    dst_idle = 8;
    write_enable(1'b0);
    random_phase(400);
    wait_idle();

    src_idle = 0;
    dst_idle = 0;
    write_enable(1'b1);
    random_phase(420);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (sb.fails == 0 && sb.pending_rgb.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
